/* rtl/papt_pkg.sv */
// Shared types and constants of the polygon area point test block.
`timescale 1ns / 1ps
package papt_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MIN_VERTICES     = 3;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	typedef struct packed {
		logic load_item;
		logic rd_en;
		logic rd_edge;
		logic commit;
	} papt_cmd_t;

	typedef struct packed {
		logic walk_ok;
	} papt_status_t;

endpackage

/* rtl/polygon_area_point_test.sv */
// Top level of the polygon area point test block.
`timescale 1ns / 1ps
// Holds up to MAX_VERTICES polygon vertices in Q16.16 and answers even-odd
// point-in-polygon queries, one item at a time, each giving one result transfer.
// Clear, append and unused kinds pass from the check state straight to the done
// state. A query whose map id matches and that has n >= 3 vertices also passes
// through a walk: the edge unit reads one vertex per cycle from the vertex
// memory (n + 1 reads, the closing edge included) and then drains a 3-stage
// setup/multiply/compare pipeline. A finished result waits in the output
// register while the next item is taken in.
module polygon_area_point_test
	import papt_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [15:0]        query_map_id,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               inside_res,
	output logic               bounds_valid,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y,
	output logic [6:0]         vertex_total,
	output logic               overflow
);

	papt_cmd_t     cmd;
	papt_status_t  status;
	logic [CW-1:0] count;
	logic [AW-1:0] rd_addr;

	papt_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.count     (count),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	papt_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.query_map_id (query_map_id),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.status       (status),
		.count        (count),
		.inside_res   (inside_res),
		.bounds_valid (bounds_valid),
		.min_x        (min_x),
		.min_y        (min_y),
		.max_x        (max_x),
		.max_y        (max_y),
		.vertex_total (vertex_total),
		.overflow     (overflow)
	);

endmodule

/* rtl/papt_ctrl.sv */
// Controller: sequences item load, vertex walk, pipeline drain and result commit.
`timescale 1ns / 1ps
module papt_ctrl
	import papt_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  papt_status_t  status,
	input  logic [CW-1:0] count,
	output papt_cmd_t     cmd,
	output logic [AW-1:0] rd_addr
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	logic [2:0]    state_q;
	logic [CW-1:0] rd_cnt_q;
	logic [1:0]    drain_q;
	logic          out_valid_q;
	logic          slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load_item = (state_q == ST_IDLE) && in_valid;
		cmd.rd_en     = (state_q == ST_WALK);
		cmd.rd_edge   = (state_q == ST_WALK) && (rd_cnt_q != '0);
		cmd.commit    = (state_q == ST_DONE) && slot_free;
		if (rd_cnt_q == '0) begin
			rd_addr = AW'(count - 1'b1);
		end else begin
			rd_addr = AW'(rd_cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rd_cnt_q <= '0;
					drain_q  <= '0;
					state_q  <= status.walk_ok ? ST_WALK : ST_DONE;
				end
				ST_WALK: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == count) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/papt_dp.sv */
// Datapath: vertex memory, bounding box, edge crossing pipeline and result register.
`timescale 1ns / 1ps
module papt_dp
	import papt_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic [1:0]          kind,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic [15:0]         query_map_id,
	input  papt_cmd_t           cmd,
	input  logic [AW-1:0]       rd_addr,
	output papt_status_t        status,
	output logic [CW-1:0]       count,
	output logic                inside_res,
	output logic                bounds_valid,
	output logic signed [31:0]  min_x,
	output logic signed [31:0]  min_y,
	output logic signed [31:0]  max_x,
	output logic signed [31:0]  max_y,
	output logic [6:0]          vertex_total,
	output logic                overflow
);

	logic signed [31:0] mem_x [MAX_VERTICES];
	logic signed [31:0] mem_y [MAX_VERTICES];

	logic [15:0]        map_id_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;

	logic [1:0]         kind_q;
	logic signed [31:0] tx_q, ty_q;
	logic [15:0]        qid_q;
	logic               parity_q;

	logic signed [31:0] rd_x_s1, rd_y_s1;
	logic               rd_v_s1, edge_s1;
	logic signed [31:0] prev_x_q, prev_y_q;

	logic signed [32:0] a_s2, b_s2, c_s2, e_s2;
	logic               edge_s2;
	logic signed [65:0] lhs_s3, rhs_s3;
	logic               edge_s3;

	logic signed [32:0] d_w, a_w, c_w, e_w, b_w;
	logic               cross_w;

	logic [CW-1:0]      count_n;
	logic signed [31:0] bmin_x_n, bmin_y_n, bmax_x_n, bmax_y_n;
	logic               ovf_n, full_w, wr_en;

	assign count        = count_q;
	assign full_w       = (count_q >= CW'(MAX_VERTICES));
	assign status.walk_ok = (kind_q == KIND_QUERY) && (qid_q == map_id_q)
		&& (count_q >= CW'(MIN_VERTICES));

	// edge setup: fold the sign of the y difference into both sides
	always_comb begin
		cross_w = (rd_y_s1 > ty_q) != (prev_y_q > ty_q);
		d_w = {prev_y_q[31], prev_y_q} - {rd_y_s1[31], rd_y_s1};
		a_w = {tx_q[31], tx_q} - {rd_x_s1[31], rd_x_s1};
		c_w = {prev_x_q[31], prev_x_q} - {rd_x_s1[31], rd_x_s1};
		if (d_w < 0) begin
			b_w = -d_w;
			e_w = {rd_y_s1[31], rd_y_s1} - {ty_q[31], ty_q};
		end else begin
			b_w = d_w;
			e_w = {ty_q[31], ty_q} - {rd_y_s1[31], rd_y_s1};
		end
	end

	always_comb begin
		count_n  = count_q;
		bmin_x_n = bmin_x_q;
		bmin_y_n = bmin_y_q;
		bmax_x_n = bmax_x_q;
		bmax_y_n = bmax_y_q;
		ovf_n    = 1'b0;
		wr_en    = 1'b0;
		case (kind_q)
			KIND_CLEAR: begin
				count_n  = '0;
				bmin_x_n = '0;
				bmin_y_n = '0;
				bmax_x_n = '0;
				bmax_y_n = '0;
			end
			KIND_APPEND: begin
				if (full_w) begin
					ovf_n = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
					if (count_q == '0) begin
						bmin_x_n = tx_q;
						bmax_x_n = tx_q;
						bmin_y_n = ty_q;
						bmax_y_n = ty_q;
					end else begin
						if (tx_q < bmin_x_q) bmin_x_n = tx_q;
						if (tx_q > bmax_x_q) bmax_x_n = tx_q;
						if (ty_q < bmin_y_q) bmin_y_n = ty_q;
						if (ty_q > bmax_y_q) bmax_y_n = ty_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem_x[count_q[AW-1:0]] <= tx_q;
			mem_y[count_q[AW-1:0]] <= ty_q;
		end
		if (cmd.rd_en) begin
			rd_x_s1 <= mem_x[rd_addr];
			rd_y_s1 <= mem_y[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			tx_q   <= coord_x;
			ty_q   <= coord_y;
			qid_q  <= query_map_id;
		end
		if (rd_v_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
		a_s2   <= a_w;
		b_s2   <= b_w;
		c_s2   <= c_w;
		e_s2   <= e_w;
		lhs_s3 <= a_s2 * b_s2;
		rhs_s3 <= c_s2 * e_s2;
		if (cmd.commit) begin
			inside_res   <= (kind_q == KIND_QUERY) && parity_q;
			bounds_valid <= (count_n >= CW'(MIN_VERTICES)) && (map_id_q != '0);
			min_x        <= bmin_x_n;
			min_y        <= bmin_y_n;
			max_x        <= bmax_x_n;
			max_y        <= bmax_y_n;
			vertex_total <= 7'(count_n);
			overflow     <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_id_q <= '0;
			count_q  <= '0;
			bmin_x_q <= '0;
			bmin_y_q <= '0;
			bmax_x_q <= '0;
			bmax_y_q <= '0;
			parity_q <= 1'b0;
			rd_v_s1  <= 1'b0;
			edge_s1  <= 1'b0;
			edge_s2  <= 1'b0;
			edge_s3  <= 1'b0;
		end else begin
			if (cfg_we) begin
				map_id_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				count_q  <= count_n;
				bmin_x_q <= bmin_x_n;
				bmin_y_q <= bmin_y_n;
				bmax_x_q <= bmax_x_n;
				bmax_y_q <= bmax_y_n;
			end
			rd_v_s1 <= cmd.rd_en;
			edge_s1 <= cmd.rd_edge;
			edge_s2 <= edge_s1 && cross_w;
			edge_s3 <= edge_s2;
			if (cmd.load_item) begin
				parity_q <= 1'b0;
			end else if (edge_s3 && (lhs_s3 < rhs_s3)) begin
				parity_q <= !parity_q;
			end
		end
	end

endmodule

/* bench/tb_top.sv */
// Testbench for the polygon area point test block: directed and random polygons, stalls.
`timescale 1ns / 1ps
module tb_top;
	import papt_pkg::*;

	localparam int         NVERT        = MAX_VERTICES_DEF;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         DRAIN_CYCLES = 80;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         CYCLE_LIMIT  = 1_000_000;
	localparam int         PHASE_ITEMS  = 215;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [15:0]        qid;
	} area_item_t;

	typedef struct {
		logic               in_area;
		logic               bvalid;
		logic signed [31:0] bx_min;
		logic signed [31:0] by_min;
		logic signed [31:0] bx_max;
		logic signed [31:0] by_max;
		logic [6:0]         total;
		logic               ovf;
	} area_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [15:0]        cfg_wdata    = '0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [1:0]         kind         = KIND_CLEAR;
	logic signed [31:0] coord_x      = '0;
	logic signed [31:0] coord_y      = '0;
	logic [15:0]        query_map_id = '0;
	logic               out_valid;
	logic               out_stall;
	logic               inside_res;
	logic               bounds_valid;
	logic signed [31:0] min_x;
	logic signed [31:0] min_y;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;
	logic [6:0]         vertex_total;
	logic               overflow;

	logic rx_stall    = 1'b0;
	logic rx_hold     = 1'b0;
	logic hold_go     = 1'b0;
	logic tx_idle_on  = 1'b1;
	logic rx_idle_on  = 1'b0;

	area_item_t   pending_q [$];
	area_result_t expected_q [$];
	area_item_t   cur_item;
	int           queued_n   = 0;
	int           accepted_n = 0;
	int           errors     = 0;
	int           cycles     = 0;
	int           tx_gap     = 0;
	int           rx_left    = 0;

	// predictor state
	logic signed [31:0] poly_x [NVERT];
	logic signed [31:0] poly_y [NVERT];
	int                 poly_count = 0;
	logic signed [31:0] box_lo_x = '0, box_lo_y = '0, box_hi_x = '0, box_hi_y = '0;
	logic [15:0]        area_id = '0;

	assign out_stall = rx_stall | rx_hold;

	polygon_area_point_test u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.query_map_id (query_map_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.inside_res   (inside_res),
		.bounds_valid (bounds_valid),
		.min_x        (min_x),
		.min_y        (min_y),
		.max_x        (max_x),
		.max_y        (max_y),
		.vertex_total (vertex_total),
		.overflow     (overflow)
	);

	always #6 clk = ~clk;

	// even-odd crossing count, exact cross-multiplied compare at 128 bits
	function automatic logic point_in_area(logic signed [31:0] tx, logic signed [31:0] ty);
		longint              dy, dx, ox, oy;
		logic signed [127:0] wa, wb, wc, wd;
		logic                par;
		int                  j;
		par = 1'b0;
		j = poly_count - 1;
		for (int i = 0; i < poly_count; i++) begin
			if ((poly_y[i] > ty) != (poly_y[j] > ty)) begin
				dy = longint'(poly_y[j]) - longint'(poly_y[i]);
				dx = longint'(poly_x[j]) - longint'(poly_x[i]);
				ox = longint'(tx) - longint'(poly_x[i]);
				oy = (dy < 0) ? longint'(poly_y[i]) - longint'(ty)
				              : longint'(ty) - longint'(poly_y[i]);
				if (dy < 0)
					dy = -dy;
				wa = ox;
				wb = dy;
				wc = dx;
				wd = oy;
				if (wa * wb < wc * wd)
					par = ~par;
			end
			j = i;
		end
		return par;
	endfunction

	function automatic area_result_t area_step(area_item_t it);
		area_result_t r;
		r.in_area = 1'b0;
		r.ovf     = 1'b0;
		case (it.kind)
			KIND_CLEAR: begin
				poly_count = 0;
				box_lo_x = '0;
				box_lo_y = '0;
				box_hi_x = '0;
				box_hi_y = '0;
			end
			KIND_APPEND: begin
				if (poly_count >= NVERT) begin
					r.ovf = 1'b1;
				end else begin
					poly_x[poly_count] = it.cx;
					poly_y[poly_count] = it.cy;
					if (poly_count == 0) begin
						box_lo_x = it.cx;
						box_hi_x = it.cx;
						box_lo_y = it.cy;
						box_hi_y = it.cy;
					end else begin
						if (it.cx < box_lo_x) box_lo_x = it.cx;
						if (it.cx > box_hi_x) box_hi_x = it.cx;
						if (it.cy < box_lo_y) box_lo_y = it.cy;
						if (it.cy > box_hi_y) box_hi_y = it.cy;
					end
					poly_count++;
				end
			end
			KIND_QUERY: begin
				if (it.qid == area_id && poly_count >= MIN_VERTICES)
					r.in_area = point_in_area(it.cx, it.cy);
			end
			default: ;
		endcase
		r.bvalid = (poly_count >= MIN_VERTICES) && (area_id != 16'd0);
		r.bx_min = box_lo_x;
		r.by_min = box_lo_y;
		r.bx_max = box_hi_x;
		r.by_max = box_hi_y;
		r.total  = 7'(poly_count);
		return r;
	endfunction

	task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_q = {expected_q, area_step(cur_item)};
				accepted_n++;
				tx_gap = tx_idle_on ? $urandom_range(0, 18) : 0;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_item = pending_q.pop_front();
					in_valid     <= 1'b1;
					kind         <= cur_item.kind;
					coord_x      <= cur_item.cx;
					coord_y      <= cur_item.cy;
					query_map_id <= cur_item.qid;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		area_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					errors++;
				end else begin
					e = expected_q.pop_front();
					field_check("inside_res", 32'(e.in_area), 32'(inside_res));
					field_check("bounds_valid", 32'(e.bvalid), 32'(bounds_valid));
					field_check("min_x", e.bx_min, min_x);
					field_check("min_y", e.by_min, min_y);
					field_check("max_x", e.bx_max, max_x);
					field_check("max_y", e.by_max, max_y);
					field_check("vertex_total", 32'(e.total), 32'(vertex_total));
					field_check("overflow", 32'(e.ovf), 32'(overflow));
				end
				rx_left = rx_idle_on ? $urandom_range(0, 18) : 0;
				rx_stall <= (rx_left > 0);
			end else if (rx_stall) begin
				rx_left--;
				if (rx_left <= 0)
					rx_stall <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic queue_item(logic [1:0] k, logic signed [31:0] x, logic signed [31:0] y,
	                          logic [15:0] q);
		area_item_t it;
		it.kind = k;
		it.cx   = x;
		it.cy   = y;
		it.qid  = q;
		pending_q = {pending_q, it};
		queued_n++;
	endtask

	function automatic logic signed [31:0] draw_coord(int style);
		int v;
		case (style)
			1: begin
				v = $urandom_range(0, 16);
				return (v - 8) * 65536;
			end
			2: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0000_0000;
					3: return -32'sd1;
					4: return 32'sd1;
					default: return 32'sh0001_0000;
				endcase
			end
			3: begin
				v = $urandom_range(0, 2097152);
				return v - 1048576;
			end
			default: return $urandom;
		endcase
	endfunction

	// one sequence of an optional clear, appends and queries with random content, or a short burst of noise
	task automatic queue_run(logic [15:0] map_id);
		int style, n, q;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 6))
				queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom));
			return;
		end
		style = $urandom_range(0, 3);
		if ($urandom_range(0, 9) != 0)
			queue_item(KIND_CLEAR, $urandom, $urandom, 16'($urandom));
		n = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 68) : $urandom_range(1, 10);
		repeat (n)
			queue_item(KIND_APPEND, draw_coord(style), draw_coord(style), 16'($urandom));
		repeat ($urandom_range(1, 8)) begin
			q = $urandom_range(0, 9);
			queue_item((q == 0) ? KIND_UNUSED : KIND_QUERY, draw_coord((q < 3) ? 0 : style),
			           draw_coord(style), (q == 1) ? 16'($urandom) : map_id);
		end
	endtask

	task automatic wait_idle();
		while (accepted_n != queued_n || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_map_id(logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		area_id = v;
	endtask

	initial begin
		logic [15:0] map_list [7];
		int          start_n;
		map_list = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF};
		map_list[3] = 16'($urandom);
		map_list[5] = 16'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_map_id(16'h00A5);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A5);
		queue_item(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
		queue_item(KIND_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0000);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A5);
		queue_item(KIND_UNUSED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h00A5);
		queue_item(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h00A5);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A5);
		queue_item(KIND_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h00A5);
		queue_item(KIND_QUERY, 32'sh8000_0000, 32'sh8000_0000, 16'h00A5);
		queue_item(KIND_CLEAR, 32'sh1234_5678, -32'sd1, 16'hFFFF);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A5);
		queue_item(KIND_APPEND, -32'sh2_0000, -32'sh2_0000, 16'h0000);
		queue_item(KIND_APPEND, 32'sh2_0000, -32'sh2_0000, 16'h0000);
		queue_item(KIND_APPEND, 32'sh2_0000, 32'sh2_0000, 16'h0000);
		queue_item(KIND_APPEND, -32'sh2_0000, 32'sh2_0000, 16'h0000);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A5);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'h00A4);
		queue_item(KIND_QUERY, 32'sh3_0000, 32'sd0, 16'h00A5);
		queue_item(KIND_QUERY, 32'sh2_0000, 32'sd0, 16'h00A5);
		queue_item(KIND_QUERY, -32'sh2_0000, -32'sh2_0000, 16'h00A5);
		queue_item(KIND_QUERY, 32'sd0, 32'sh2_0000, 16'h00A5);
		queue_item(KIND_QUERY, -32'sd1, -32'sh1_FFFF, 16'h00A5);
		queue_item(KIND_UNUSED, 32'sd0, 32'sd0, 16'h0000);
		queue_item(KIND_QUERY, 32'sd0, 32'sd0, 16'hFFFF);
		wait_idle();

		for (int p = 0; p < 7; p++) begin
			write_map_id(map_list[p]);
			tx_idle_on = (p % 3) != 2;
			rx_idle_on = (p % 2) == 0;
			start_n = queued_n;
			if (p == 3) begin
				queue_item(KIND_CLEAR, 32'sd0, 32'sd0, 16'h0000);
				repeat (NVERT + 3)
					queue_item(KIND_APPEND, draw_coord(1), draw_coord(1), 16'($urandom));
				queue_item(KIND_QUERY, draw_coord(1), draw_coord(1), map_list[p]);
				queue_item(KIND_QUERY, draw_coord(1), draw_coord(1), map_list[p]);
			end
			while (queued_n - start_n < PHASE_ITEMS)
				queue_run(map_list[p]);
			if (p == 2)
				hold_go = 1'b1;
			wait_idle();
		end

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* polygon_area_point_test.f */
rtl/papt_pkg.sv
rtl/papt_ctrl.sv
rtl/papt_dp.sv
rtl/polygon_area_point_test.sv
bench/tb_top.sv
